// ===== sv/mldf_pkg.sv =====
// Shared types, constants and the magic matcher step for the magic/length deframer.
`timescale 1ns / 1ps

package mldf_pkg;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLen  = 2'd1,
    PhPay  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindEmpty    = 2'd1,
    KindOversize = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [31:0] declared_length;
  } result_t;

  localparam logic [31:0] MaxPayloadReset = 32'd1048576;
  localparam logic [2:0]  MagicLen        = 3'd4;

  // magic word, first byte at index 0
  localparam logic [0:3][7:0] MagicWord = {8'h54, 8'h52, 8'h59, 8'h58};

  function automatic logic [2:0] match_next(logic [2:0] p, logic [7:0] b);
    logic [2:0] r;
    if (p < MagicLen && b == MagicWord[p[1:0]]) begin
      r = p + 3'd1;
    end else if (b == MagicWord[0]) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

// ===== sv/mldf_front.sv =====
// Front end: byte classifier, header parser and payload counter.
`timescale 1ns / 1ps

module mldf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output mldf_pkg::result_t   res_o
);

  mldf_pkg::phase_e phase_q, phase_d;
  logic [2:0]  prog_q, prog_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] left_q, left_d;
  logic [31:0] max_q;

  logic [31:0] len_full;
  logic [2:0]  rescan_p;
  logic [2:0]  hunt_p;
  logic        oversize;

  assign len_full = len_q | ({24'd0, byte_i} << {cnt_q, 3'b000});
  assign oversize = len_full > max_q;
  assign hunt_p   = mldf_pkg::match_next(prog_q, byte_i);
  assign rescan_p = mldf_pkg::match_next(
                      mldf_pkg::match_next(
                        mldf_pkg::match_next(
                          mldf_pkg::match_next(3'd0, len_full[7:0]),
                          len_full[15:8]),
                        len_full[23:16]),
                      len_full[31:24]);

  // next state
  always_comb begin
    phase_d = phase_q;
    prog_d  = prog_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    unique case (phase_q)
      mldf_pkg::PhLen: begin
        len_d = len_full;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = 2'd0;
          if (oversize) begin
            len_d = 32'd0;
            if (rescan_p == mldf_pkg::MagicLen) begin
              phase_d = mldf_pkg::PhLen;
              prog_d  = 3'd0;
            end else begin
              phase_d = mldf_pkg::PhHunt;
              prog_d  = rescan_p;
            end
          end else if (len_full == 32'd0) begin
            phase_d = mldf_pkg::PhHunt;
            prog_d  = 3'd0;
          end else begin
            phase_d = mldf_pkg::PhPay;
            left_d  = len_full;
          end
        end
      end
      mldf_pkg::PhPay: begin
        if (left_q != 32'd0) begin
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = mldf_pkg::PhHunt;
            prog_d  = 3'd0;
          end
        end else begin
          phase_d = mldf_pkg::PhHunt;
          if (hunt_p == mldf_pkg::MagicLen) begin
            phase_d = mldf_pkg::PhLen;
            prog_d  = 3'd0;
            len_d   = 32'd0;
            cnt_d   = 2'd0;
          end else begin
            prog_d = hunt_p;
          end
        end
      end
      default: begin
        phase_d = mldf_pkg::PhHunt;
        if (hunt_p == mldf_pkg::MagicLen) begin
          phase_d = mldf_pkg::PhLen;
          prog_d  = 3'd0;
          len_d   = 32'd0;
          cnt_d   = 2'd0;
        end else begin
          prog_d = hunt_p;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid_o           = 1'b0;
    res_o.kind            = mldf_pkg::KindPayload;
    res_o.payload_byte    = 8'd0;
    res_o.last_of_frame   = 1'b0;
    res_o.declared_length = 32'd0;
    unique case (phase_q)
      mldf_pkg::PhLen: begin
        if (cnt_q == 2'd3) begin
          if (oversize) begin
            res_valid_o           = byte_valid_i;
            res_o.kind            = mldf_pkg::KindOversize;
            res_o.declared_length = len_full;
          end else if (len_full == 32'd0) begin
            res_valid_o = byte_valid_i;
            res_o.kind  = mldf_pkg::KindEmpty;
          end
        end
      end
      mldf_pkg::PhPay: begin
        if (left_q != 32'd0) begin
          res_valid_o           = byte_valid_i;
          res_o.payload_byte    = byte_i;
          res_o.last_of_frame   = (left_q == 32'd1);
          res_o.declared_length = len_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mldf_pkg::PhHunt;
      prog_q  <= 3'd0;
      len_q   <= 32'd0;
      cnt_q   <= 2'd0;
      left_q  <= 32'd0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      prog_q  <= prog_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= mldf_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  a_oversize_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == mldf_pkg::KindOversize |-> res_o.declared_length > max_q)
    else $error("oversize reported for a length within the limit");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_of_frame |=> phase_q == mldf_pkg::PhHunt && prog_q == 3'd0)
    else $error("last payload byte did not return to the hunt");

  a_pay_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mldf_pkg::PhPay |-> left_q != 32'd0)
    else $error("payload phase with no bytes left");

  a_cnt_only_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 |-> phase_q == mldf_pkg::PhLen)
    else $error("length byte count set outside length collection");

endmodule

// ===== sv/mldf_fifo.sv =====
// Back end: result queue that decouples the parser from the consumer.
`timescale 1ns / 1ps

module mldf_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mldf_pkg::result_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mldf_pkg::result_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);

  mldf_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/magic_length_deframer_core.sv =====
// Top level of the magic-word, length-prefixed byte stream deframer.
//
//  channel   direction  handshake      payload
//  input     in         push / full    data_byte_i
//  result    out        pop / empty    kind_o, payload_byte_o, last_of_frame_o,
//                                      declared_length_o
//  config    in         cfg_we_i       cfg_wdata_i (max_payload)
//
// One byte per cycle is accepted while full is low; each byte is parsed in the cycle it is pushed.
// A result is readable in the cycle after its byte, through a FifoDepth-entry queue.
// full rises only when the queue holds FifoDepth unread results; while it is high
// no byte is taken, including bytes that would produce no result.
// Reset clears the parser to the hunt and max_payload to 1048576.
`timescale 1ns / 1ps

module magic_length_deframer_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o,
  output logic [31:0] declared_length_o
);

  logic              accept;
  logic              res_valid;
  mldf_pkg::result_t res;
  mldf_pkg::result_t head;

  assign accept = push && !full;

  mldf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (accept),
    .byte_i       (data_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mldf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  assign kind_o            = head.kind;
  assign payload_byte_o    = head.payload_byte;
  assign last_of_frame_o   = head.last_of_frame;
  assign declared_length_o = head.declared_length;

endmodule
